// ===== rtl/core/bsce_pkg.sv =====
// Shared types, codes and helper functions for the blower serial command engine.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package bsce_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OP_COMMAND   = 2'd0;
  localparam logic [1:0] OP_RX_BYTE   = 2'd1;
  localparam logic [1:0] OP_END_REPLY = 2'd2;

  // Command codes.
  localparam logic [2:0] CMD_START      = 3'd0;
  localparam logic [2:0] CMD_STOP       = 3'd1;
  localparam logic [2:0] CMD_SET_MODE   = 3'd2;
  localparam logic [2:0] CMD_SET_SPEED  = 3'd3;
  localparam logic [2:0] CMD_READ_MODE  = 3'd4;
  localparam logic [2:0] CMD_READ_SPEED = 3'd5;
  localparam logic [2:0] CMD_READ_FAULT = 3'd6;
  localparam logic [2:0] CMD_READ_RUN   = 3'd7;

  // Reply status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_LENGTH  = 3'd1;
  localparam logic [2:0] ST_BAD_CRC     = 3'd2;
  localparam logic [2:0] ST_UNKNOWN_MOD = 3'd3;
  localparam logic [2:0] ST_NO_REPLY    = 3'd4;

  // Result kinds.
  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Register indexes of the configuration port.
  localparam logic REG_DEVICE_ADDRESS = 1'b0;
  localparam logic REG_SPEED_CEILING  = 1'b1;

  // Frame constants.
  localparam logic [7:0]  ACK_BYTE        = 8'h20;
  localparam logic [7:0]  MODE_TORQUE     = 8'h55;
  localparam logic [7:0]  MODE_AIRFLOW    = 8'h22;
  localparam logic [7:0]  READ_MODE_ARG   = 8'h05;
  localparam logic [7:0]  READ_SPEED_ARG  = 8'h01;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [3:0]  COUNT_MAX       = 4'd15;

  // Reset values of the configuration registers.
  localparam logic [7:0]  DEV_ADDR_RESET  = 8'd21;
  localparam logic [15:0] CEILING_RESET   = 16'd3000;

  // Default depth of the job queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // One unit of work for the back end: either a frame to send or a status to report.
  typedef struct packed {
    logic        is_status;
    logic [2:0]  cmd;
    logic        air;
    logic [7:0]  addr;
    logic [15:0] first;
    logic [15:0] second;
    logic [2:0]  status;
    logic [31:0] value;
  } bsce_job_t;

  // One byte through the Modbus CRC16 (reflected polynomial).
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] func_code(input logic [2:0] cmd);
    logic [7:0] f;
    unique case (cmd)
      CMD_START:      f = 8'h41;
      CMD_STOP:       f = 8'h42;
      CMD_SET_MODE:   f = 8'h38;
      CMD_SET_SPEED:  f = 8'h44;
      CMD_READ_MODE:  f = 8'h3A;
      CMD_READ_SPEED: f = 8'h45;
      CMD_READ_FAULT: f = 8'h50;
      default:        f = 8'h59;
    endcase
    return f;
  endfunction

  // Number of bytes a well-formed reply to each command has.
  function automatic logic [3:0] expect_len(input logic [2:0] cmd);
    logic [3:0] n;
    unique case (cmd)
      CMD_START:      n = 4'd5;
      CMD_STOP:       n = 4'd5;
      CMD_SET_MODE:   n = 4'd10;
      CMD_SET_SPEED:  n = 4'd8;
      CMD_READ_MODE:  n = 4'd11;
      CMD_READ_SPEED: n = 4'd8;
      CMD_READ_FAULT: n = 4'd7;
      default:        n = 4'd9;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/blower_serial_command_engine.sv =====
// A result passes through the job queue and then the back end's output register to the outputs.
// Throughput: one input item per cycle while the job queue (four entries by default) has room;
// the back end sends one result per cycle while results are taken, one result per byte of a
// command frame of 5 to 10 bytes. Reply-byte items produce no result and never reach the queue.
// Reset: rst_n is synchronous and active low; it empties the queue and output register,
// ends any open exchange and sets device_address to 21 and speed_ceiling to 3000.
`timescale 1ns / 1ps
`default_nettype none

module blower_serial_command_engine #(
  parameter int QUEUE_DEPTH = bsce_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel: a transfer happens when push is high and full is low.
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  in_operation,
  input  wire logic [2:0]  in_command,
  input  wire logic        in_airflow_mode,
  input  wire logic [15:0] in_first_value,
  input  wire logic [15:0] in_second_value,
  input  wire logic [7:0]  in_rx_byte,
  // Result channel: a transfer happens when pop is high and empty is low.
  output logic             empty,
  input  wire logic        pop,
  output logic             out_result_kind,
  output logic [7:0]       out_tx_byte,
  output logic             out_tx_last,
  output logic [2:0]       out_status,
  output logic [31:0]      out_reply_value,
  output logic [2:0]       out_reply_command,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import bsce_pkg::*;

  logic        in_xfer;
  logic        out_xfer;
  logic        cfg_write;
  logic [7:0]  dev_addr_r;
  logic [15:0] ceiling_r;

  bsce_job_t   front_job;
  logic        front_push;
  bsce_job_t   back_job;
  logic        q_full;
  logic        q_empty;
  logic        back_pop;
  logic        back_valid;

  // The front end never stalls on its own; only a full job queue holds back a transfer.
  assign full     = q_full;
  assign in_xfer  = push && !q_full;
  assign empty    = !back_valid;
  assign out_xfer = pop && back_valid;

  // Configuration registers sit at byte addresses 0 and 4; the port never waits.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RESET;
      ceiling_r  <= CEILING_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_DEVICE_ADDRESS) begin
        dev_addr_r <= pwdata[7:0];
      end else begin
        ceiling_r <= pwdata[15:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_SPEED_CEILING) ? {16'h0000, ceiling_r}
                                                  : {24'h000000, dev_addr_r};

  // Front end: keeps the exchange state (reply count, reply CRC, field bytes) and turns each
  // command item, and each end-of-reply item while an exchange is open, into one job.
  bsce_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (in_xfer),
    .operation      (in_operation),
    .command        (in_command),
    .airflow_mode   (in_airflow_mode),
    .first_value    (in_first_value),
    .second_value   (in_second_value),
    .rx_byte        (in_rx_byte),
    .device_address (dev_addr_r),
    .speed_ceiling  (ceiling_r),
    .job            (front_job),
    .job_push       (front_push)
  );

  // Job queue decouples item intake from frame serialization.
  bsce_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (front_push),
    .wr_data (front_job),
    .full    (q_full),
    .rd_en   (back_pop),
    .rd_data (back_job),
    .empty   (q_empty)
  );

  // Back end: expands a frame job into bytes with the CRC appended low byte first, or
  // forwards a status job, one result per cycle while its output register is free or taken.
  bsce_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .job               (back_job),
    .job_valid         (!q_empty),
    .job_pop           (back_pop),
    .out_take          (out_xfer),
    .out_valid         (back_valid),
    .out_result_kind   (out_result_kind),
    .out_tx_byte       (out_tx_byte),
    .out_tx_last       (out_tx_last),
    .out_status        (out_status),
    .out_reply_value   (out_reply_value),
    .out_reply_command (out_reply_command)
  );

endmodule

`default_nettype wire

// ===== rtl/core/bsce_front.sv =====
// Front end: takes input items, tracks the reply exchange and queues jobs.
// Depends on bsce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsce_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic [1:0]          operation,
  input  wire logic [2:0]          command,
  input  wire logic                airflow_mode,
  input  wire logic [15:0]         first_value,
  input  wire logic [15:0]         second_value,
  input  wire logic [7:0]          rx_byte,
  input  wire logic [7:0]          device_address,
  input  wire logic [15:0]         speed_ceiling,
  output bsce_pkg::bsce_job_t      job,
  output logic                     job_push
);
  import bsce_pkg::*;

  logic [2:0]  pend_cmd_r, pend_cmd_nxt;
  logic        pend_air_r, pend_air_nxt;
  logic        awaiting_r, awaiting_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        stored_air_r, stored_air_nxt;
  logic [7:0]  field_r [4];
  logic        field_we;
  logic [1:0]  field_idx;

  logic [2:0]  reply_status;
  logic [31:0] reply_value;
  logic [15:0] speed;

  // Field bytes are reply bytes three to six.
  assign field_idx = count_r[1:0] - 2'd3;
  assign speed     = {field_r[2], field_r[1]};

  always_comb begin
    reply_status = ST_OK;
    reply_value  = '0;
    if (count_r == 4'd0) begin
      reply_status = ST_NO_REPLY;
    end else if (count_r != expect_len(pend_cmd_r)) begin
      reply_status = ST_BAD_LENGTH;
    end else if (crc_r != 16'h0000) begin
      reply_status = ST_BAD_CRC;
    end else begin
      unique case (pend_cmd_r)
        CMD_READ_MODE: begin
          if (field_r[1] == MODE_AIRFLOW) begin
            reply_value = 32'd1;
          end else if (field_r[1] != MODE_TORQUE) begin
            reply_status = ST_UNKNOWN_MOD;
          end
        end
        CMD_READ_SPEED: begin
          reply_value = (speed > speed_ceiling) ? 32'd0 : {16'h0000, speed};
        end
        CMD_READ_FAULT: reply_value = {16'h0000, field_r[1], field_r[0]};
        CMD_READ_RUN:   reply_value = {field_r[3], field_r[2], field_r[1], field_r[0]};
        default:        reply_value = '0;
      endcase
    end
  end

  always_comb begin
    pend_cmd_nxt   = pend_cmd_r;
    pend_air_nxt   = pend_air_r;
    awaiting_nxt   = awaiting_r;
    count_nxt      = count_r;
    crc_nxt        = crc_r;
    stored_air_nxt = stored_air_r;
    field_we       = 1'b0;
    job_push       = 1'b0;
    job            = '0;
    if (accept) begin
      unique case (operation)
        OP_COMMAND: begin
          job.is_status = 1'b0;
          job.cmd       = command;
          job.air       = (command == CMD_SET_MODE) ? airflow_mode : stored_air_r;
          job.addr      = device_address;
          job.first     = first_value;
          job.second    = second_value;
          job_push      = 1'b1;
          pend_cmd_nxt  = command;
          pend_air_nxt  = airflow_mode;
          awaiting_nxt  = 1'b1;
          count_nxt     = '0;
          crc_nxt       = CRC_INIT;
        end
        OP_RX_BYTE: begin
          if (awaiting_r) begin
            field_we = (count_r >= 4'd3) && (count_r <= 4'd6);
            crc_nxt  = crc16_byte(crc_r, rx_byte);
            if (count_r != COUNT_MAX) begin
              count_nxt = count_r + 4'd1;
            end
          end
        end
        OP_END_REPLY: begin
          if (awaiting_r) begin
            job.is_status = 1'b1;
            job.cmd       = pend_cmd_r;
            job.status    = reply_status;
            job.value     = (reply_status == ST_OK) ? reply_value : 32'd0;
            job_push      = 1'b1;
            awaiting_nxt  = 1'b0;
            count_nxt     = '0;
            crc_nxt       = CRC_INIT;
            if (reply_status == ST_OK && pend_cmd_r == CMD_SET_MODE) begin
              stored_air_nxt = pend_air_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_cmd_r   <= '0;
      pend_air_r   <= 1'b0;
      awaiting_r   <= 1'b0;
      count_r      <= '0;
      crc_r        <= CRC_INIT;
      stored_air_r <= 1'b0;
    end else begin
      pend_cmd_r   <= pend_cmd_nxt;
      pend_air_r   <= pend_air_nxt;
      awaiting_r   <= awaiting_nxt;
      count_r      <= count_nxt;
      crc_r        <= crc_nxt;
      stored_air_r <= stored_air_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (field_we) begin
      field_r[field_idx] <= rx_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bsce_queue.sv =====
// Short job queue between the front and back ends of the engine.
// Depends on bsce_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module bsce_queue #(
  parameter int DEPTH = bsce_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                wr_en,
  input  wire bsce_pkg::bsce_job_t wr_data,
  output logic                     full,
  input  wire logic                rd_en,
  output bsce_pkg::bsce_job_t      rd_data,
  output logic                     empty
);
  import bsce_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bsce_job_t         slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && full)) else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && empty)) else $error("job queue read while empty");

endmodule

`default_nettype wire

// ===== rtl/core/bsce_back.sv =====
// Back end: turns queued jobs into frame bytes with a running CRC, or a status result,
// and holds each result in an output register. Depends on bsce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsce_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bsce_pkg::bsce_job_t job,
  input  wire logic                job_valid,
  output logic                     job_pop,
  input  wire logic                out_take,
  output logic                     out_valid,
  output logic                     out_result_kind,
  output logic [7:0]               out_tx_byte,
  output logic                     out_tx_last,
  output logic [2:0]               out_status,
  output logic [31:0]              out_reply_value,
  output logic [2:0]               out_reply_command
);
  import bsce_pkg::*;

  logic [3:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        valid_r, valid_nxt;
  logic        kind_r;
  logic [7:0]  byte_r;
  logic        last_r;
  logic [2:0]  status_r;
  logic [31:0] value_r;
  logic [2:0]  cmd_r;

  logic        load;
  logic [3:0]  data_len;
  logic [7:0]  mode_byte;
  logic [7:0]  data_byte;
  logic [7:0]  tx_byte;
  logic        is_data;
  logic        is_last;

  assign load      = job_valid && (!valid_r || out_take);
  assign mode_byte = job.air ? MODE_AIRFLOW : MODE_TORQUE;

  always_comb begin
    unique case (job.cmd)
      CMD_SET_MODE:   data_len = 4'd8;
      CMD_SET_SPEED:  data_len = 4'd6;
      CMD_READ_MODE:  data_len = 4'd4;
      CMD_READ_SPEED: data_len = 4'd4;
      default:        data_len = 4'd3;
    endcase
  end

  always_comb begin
    priority case (idx_r)
      4'd0: data_byte = job.addr;
      4'd1: data_byte = func_code(job.cmd);
      4'd2: data_byte = ACK_BYTE;
      4'd3: begin
        if (job.cmd == CMD_SET_MODE || job.cmd == CMD_SET_SPEED) begin
          data_byte = mode_byte;
        end else if (job.cmd == CMD_READ_MODE) begin
          data_byte = READ_MODE_ARG;
        end else begin
          data_byte = READ_SPEED_ARG;
        end
      end
      4'd4:    data_byte = job.first[7:0];
      4'd5:    data_byte = job.first[15:8];
      4'd6:    data_byte = job.second[7:0];
      default: data_byte = job.second[15:8];
    endcase
  end

  assign is_data = (idx_r < data_len);
  assign is_last = (idx_r == data_len + 4'd1);

  always_comb begin
    if (is_data) begin
      tx_byte = data_byte;
    end else if (idx_r == data_len) begin
      tx_byte = crc_r[7:0];
    end else begin
      tx_byte = crc_r[15:8];
    end
  end

  always_comb begin
    idx_nxt   = idx_r;
    crc_nxt   = crc_r;
    job_pop   = 1'b0;
    valid_nxt = valid_r;
    if (out_take) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
      if (job.is_status) begin
        job_pop = 1'b1;
      end else if (is_last) begin
        job_pop = 1'b1;
        idx_nxt = '0;
        crc_nxt = CRC_INIT;
      end else begin
        idx_nxt = idx_r + 4'd1;
        if (is_data) begin
          crc_nxt = crc16_byte(crc_r, data_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      crc_r   <= CRC_INIT;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      crc_r   <= crc_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= job.is_status ? KIND_STATUS : KIND_TX;
      byte_r   <= job.is_status ? 8'h00 : tx_byte;
      last_r   <= job.is_status ? 1'b0 : is_last;
      status_r <= job.is_status ? job.status : ST_OK;
      value_r  <= job.is_status ? job.value : 32'd0;
      cmd_r    <= job.cmd;
    end
  end

  assign out_valid         = valid_r;
  assign out_result_kind   = kind_r;
  assign out_tx_byte       = byte_r;
  assign out_tx_last       = last_r;
  assign out_status        = status_r;
  assign out_reply_value   = value_r;
  assign out_reply_command = cmd_r;

  a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= 4'd9) else $error("frame byte index past the longest frame");

  a_frame_end_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    (load && !job.is_status && is_last) |=> (idx_r == 4'd0 && crc_r == CRC_INIT))
    else $error("frame serializer not rewound after last byte");

endmodule

`default_nettype wire
